// ===== hdl/jac_pkg.sv =====
package jac_pkg;

  // Sample and calibration widths
  localparam int ADC_BITS = 12;
  localparam int CAL_W    = 12;
  localparam int VAL_W    = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;
  // A difference times 100 needs seven more bits
  localparam int NUM_W    = VAL_W + 7;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int QUO_W    = 8;
  localparam int POS_W    = 8;
  localparam int CALC_W   = 10;
  localparam int DB_W     = 7;
  localparam int INV_W    = 2;
  localparam int IDX_W    = 4;
  localparam int DATA_W   = CAL_W;

  localparam logic signed [CALC_W-1:0] POS_LIMIT = CALC_W'(100);
  localparam logic signed [CALC_W-1:0] NEG_LIMIT = -POS_LIMIT;

  // Register reset values
  localparam logic [CAL_W-1:0] MIN_RST    = CAL_W'(100);
  localparam logic [CAL_W-1:0] CENTER_RST = CAL_W'(2048);
  localparam logic [CAL_W-1:0] MAX_RST    = CAL_W'(4000);
  localparam logic [DB_W-1:0]  DB_RST     = DB_W'(5);
  localparam logic [INV_W-1:0] INV_RST    = INV_W'(3);

  typedef enum logic [IDX_W-1:0] {
    REG_X_MIN    = IDX_W'(0),
    REG_X_CENTER = IDX_W'(1),
    REG_X_MAX    = IDX_W'(2),
    REG_Y_MIN    = IDX_W'(3),
    REG_Y_CENTER = IDX_W'(4),
    REG_Y_MAX    = IDX_W'(5),
    REG_DEAD     = IDX_W'(6),
    REG_INVERT   = IDX_W'(7)
  } cfg_reg_t;

  // Per-axis division job: magnitudes plus the flags needed afterward
  typedef struct packed {
    logic             lo;
    logic             zero;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [CAL_W-1:0] span;
  } axis_job_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

  // Pick the half-span, form |num|*100 and |span| and the quotient sign
  function automatic axis_job_t axis_prep(input logic [ADC_BITS-1:0] raw,
                                          input logic [CAL_W-1:0] mn,
                                          input logic [CAL_W-1:0] c,
                                          input logic [CAL_W-1:0] mx);
    logic [VAL_W:0]        r_e;
    logic [VAL_W:0]        mn_e;
    logic [VAL_W:0]        c_e;
    logic [VAL_W:0]        mx_e;
    logic signed [VAL_W:0] num_s;
    logic signed [VAL_W:0] span_s;
    logic [VAL_W:0]        span_m;
    logic [VAL_W-1:0]      num_m;
    logic [NUM_W-1:0]      n;
    axis_job_t             j;
    r_e    = (VAL_W+1)'(raw);
    mn_e   = (VAL_W+1)'(mn);
    c_e    = (VAL_W+1)'(c);
    mx_e   = (VAL_W+1)'(mx);
    j.lo   = r_e < c_e;
    num_s  = signed'(j.lo ? (r_e - mn_e) : (r_e - c_e));
    span_s = signed'(j.lo ? (c_e - mn_e) : (mx_e - c_e));
    num_m  = num_s[VAL_W] ? VAL_W'(unsigned'(-num_s)) : num_s[VAL_W-1:0];
    span_m = span_s[VAL_W] ? unsigned'(-span_s) : unsigned'(span_s);
    n      = NUM_W'(num_m);
    j.num  = (n << 6) + (n << 5) + (n << 2);
    j.span = span_m[CAL_W-1:0];
    j.zero = (span_s == '0);
    j.neg  = num_s[VAL_W] ^ span_s[VAL_W];
    return j;
  endfunction

  // Apply sign and offset, clamp, zero an empty span, invert, dead band
  function automatic logic [POS_W-1:0] axis_finish(input axis_job_t j,
                                                   input logic [QUO_W-1:0] quo,
                                                   input logic inv,
                                                   input logic [DB_W-1:0] db);
    logic signed [CALC_W-1:0] m;
    logic signed [CALC_W-1:0] q;
    logic signed [CALC_W-1:0] v;
    logic [CALC_W-1:0]        mag;
    m = signed'(CALC_W'(quo));
    q = j.neg ? -m : m;
    v = j.lo ? (q - POS_LIMIT) : q;
    if (v < NEG_LIMIT) v = NEG_LIMIT;
    if (v > POS_LIMIT) v = POS_LIMIT;
    if (j.zero) v = '0;
    if (inv) v = -v;
    mag = v[CALC_W-1] ? unsigned'(-v) : unsigned'(v);
    if (mag <= CALC_W'(db)) v = '0;
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/jac_div.sv =====
module jac_div (
  input  logic                         clk,
  input  jac_pkg::div_ctl_t            ctl,
  input  logic [jac_pkg::NUM_W-1:0]    dividend,
  input  logic [jac_pkg::CAL_W-1:0]    divisor,
  output logic [jac_pkg::QUO_W-1:0]    quotient
);
  import jac_pkg::*;

  logic [NUM_W-1:0] dvd;
  logic [CAL_W-1:0] dvs;
  logic [CAL_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic             sat;
  logic [CAL_W:0]   rem_sh;
  logic [CAL_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit, try subtract
  always_comb begin
    rem_sh = {rem, dvd[NUM_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    fits   = rem_sh >= {1'b0, dvs};
  end

  // Load on start, advance one quotient bit per step; note any bit lost off the top
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (ctl.step) begin
      dvd <= {dvd[NUM_W-2:0], 1'b0};
      rem <= fits ? diff[CAL_W-1:0] : rem_sh[CAL_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
      sat <= sat | quo[QUO_W-1];
    end
  end

  // Saturate: any quotient past the range reads as all ones
  assign quotient = sat ? '1 : quo;

endmodule

// ===== hdl/joystick_axis_conditioner.sv =====
// Joystick axis conditioner: takes a pair of ADC samples (raw_x, raw_y) and
// returns pos_x and pos_y in -100..+100 plus a moved flag that is set when
// either position differs from the previous result (both start at zero after
// reset). Each axis maps linearly from its min/center/max calibration, then
// is clamped, optionally negated by invert_mask and zeroed inside dead_band;
// a zero-width half-span gives 0. The two axes run side by side through
// bit-serial restoring dividers that produce one quotient bit per cycle
// over the NUM_W-bit scaled numerator, and the output register is then
// written from the quotients. The input stalls while an item is in work;
// a finished result waits until the output register is free, and the next
// item is taken on the cycle after it has been written there, so the block
// takes no new item until the last one is through.
// Configuration writes are always ready and must be issued while idle.
module joystick_axis_conditioner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [jac_pkg::ADC_BITS-1:0]       raw_x,
  input  logic [jac_pkg::ADC_BITS-1:0]       raw_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [jac_pkg::POS_W-1:0]   pos_x,
  output logic signed [jac_pkg::POS_W-1:0]   pos_y,
  output logic                               moved,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jac_pkg::IDX_W-1:0]          cfg_index,
  input  logic [jac_pkg::DATA_W-1:0]         cfg_data
);
  import jac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic [CAL_W-1:0] x_min_cal;
  logic [CAL_W-1:0] x_center_cal;
  logic [CAL_W-1:0] x_max_cal;
  logic [CAL_W-1:0] y_min_cal;
  logic [CAL_W-1:0] y_center_cal;
  logic [CAL_W-1:0] y_max_cal;
  logic [DB_W-1:0]  dead_band;
  logic [INV_W-1:0] invert_mask;

  axis_job_t        prep_x;
  axis_job_t        prep_y;
  axis_job_t        job_x;
  axis_job_t        job_y;
  div_ctl_t         dctl;
  logic [QUO_W-1:0] quo_x;
  logic [QUO_W-1:0] quo_y;
  logic [POS_W-1:0] res_x;
  logic [POS_W-1:0] res_y;
  logic [POS_W-1:0] prev_x;
  logic [POS_W-1:0] prev_y;
  logic             in_xfer;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min_cal    <= MIN_RST;
      x_center_cal <= CENTER_RST;
      x_max_cal    <= MAX_RST;
      y_min_cal    <= MIN_RST;
      y_center_cal <= CENTER_RST;
      y_max_cal    <= MAX_RST;
      dead_band    <= DB_RST;
      invert_mask  <= INV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_MIN:    x_min_cal    <= cfg_data[CAL_W-1:0];
        REG_X_CENTER: x_center_cal <= cfg_data[CAL_W-1:0];
        REG_X_MAX:    x_max_cal    <= cfg_data[CAL_W-1:0];
        REG_Y_MIN:    y_min_cal    <= cfg_data[CAL_W-1:0];
        REG_Y_CENTER: y_center_cal <= cfg_data[CAL_W-1:0];
        REG_Y_MAX:    y_max_cal    <= cfg_data[CAL_W-1:0];
        REG_DEAD:     dead_band    <= cfg_data[DB_W-1:0];
        REG_INVERT:   invert_mask  <= cfg_data[INV_W-1:0];
        default:      ;
      endcase
    end
  end

  // Form each axis job from the live samples
  always_comb begin
    prep_x = axis_prep(raw_x, x_min_cal, x_center_cal, x_max_cal);
    prep_y = axis_prep(raw_y, y_min_cal, y_center_cal, y_max_cal);
  end

  // Capture the per-axis job on an input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      job_x <= prep_x;
      job_y <= prep_y;
    end
  end

  // Dividers load with the job and step while running
  always_comb begin
    dctl.start = in_xfer;
    dctl.step  = (state == S_RUN);
  end

  jac_div u_div_x (
    .clk      (clk),
    .ctl      (dctl),
    .dividend (prep_x.num),
    .divisor  (prep_x.span),
    .quotient (quo_x)
  );

  jac_div u_div_y (
    .clk      (clk),
    .ctl      (dctl),
    .dividend (prep_y.num),
    .divisor  (prep_y.span),
    .quotient (quo_y)
  );

  // Sequence: accept, run one quotient bit per cycle, hand off to output
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_xfer) state_next = S_RUN;
      end
      S_RUN: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Finish both axes from the quotients
  always_comb begin
    res_x = axis_finish(job_x, quo_x, invert_mask[0], dead_band);
    res_y = axis_finish(job_y, quo_y, invert_mask[1], dead_band);
  end

  // Output register and previous-position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      prev_x    <= res_x;
      prev_y    <= res_y;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x <= signed'(res_x);
      pos_y <= signed'(res_y);
      moved <= (res_x != prev_x) || (res_y != prev_y);
    end
  end

endmodule

// ===== tb/joystick_axis_conditioner_checker.sv =====
module joystick_axis_conditioner_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [jac_pkg::ADC_BITS-1:0]      raw_x,
  input  logic [jac_pkg::ADC_BITS-1:0]      raw_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [jac_pkg::POS_W-1:0]  pos_x,
  input  logic signed [jac_pkg::POS_W-1:0]  pos_y,
  input  logic                              moved,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [jac_pkg::IDX_W-1:0]         cfg_index,
  input  logic [jac_pkg::DATA_W-1:0]        cfg_data,
  output int                                pending,
  output int                                results_checked,
  output int                                errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import jac_pkg::*;

  localparam int FULL_SCALE = 100;
  localparam int PRINT_CAP  = 100;
  localparam int AX_X       = 0;
  localparam int AX_Y       = 1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    moved;
  } joy_pos_t;

  // Shadow of the calibration registers, index 0 is X and 1 is Y
  logic [CAL_W-1:0]        lo_q  [2];
  logic [CAL_W-1:0]        mid_q [2];
  logic [CAL_W-1:0]        hi_q  [2];
  logic [DB_W-1:0]         dead_q;
  logic [INV_W-1:0]        flip_q;
  logic signed [POS_W-1:0] held_x;
  logic signed [POS_W-1:0] held_y;
  joy_pos_t                expected_positions [$];

  // Map one sample onto -100..+100 around its center (0 for an empty span), clamp, flip, dead band
  function automatic logic signed [POS_W-1:0] axis_percent(
    input logic [ADC_BITS-1:0] raw,
    input logic [CAL_W-1:0]    lo,
    input logic [CAL_W-1:0]    mid,
    input logic [CAL_W-1:0]    hi,
    input logic                flip,
    input logic [DB_W-1:0]     dead
  );
    int r;
    int a;
    int m;
    int b;
    int span;
    int v;
    r = int'(raw);
    a = int'(lo);
    m = int'(mid);
    b = int'(hi);
    if (r < m) begin
      span = m - a;
      v = (span == 0) ? 0 : (r - a) * FULL_SCALE / span - FULL_SCALE;
    end else begin
      span = b - m;
      v = (span == 0) ? 0 : (r - m) * FULL_SCALE / span;
    end
    if (v < -FULL_SCALE) v = -FULL_SCALE;
    if (v > FULL_SCALE) v = FULL_SCALE;
    if (flip) v = -v;
    if (((v < 0) ? -v : v) <= int'(dead)) v = 0;
    return v[POS_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : track
    joy_pos_t want;
    if (rst) begin
      lo_q[AX_X]  = MIN_RST;
      mid_q[AX_X] = CENTER_RST;
      hi_q[AX_X]  = MAX_RST;
      lo_q[AX_Y]  = MIN_RST;
      mid_q[AX_Y] = CENTER_RST;
      hi_q[AX_Y]  = MAX_RST;
      dead_q      = DB_RST;
      flip_q      = INV_RST;
      held_x      = '0;
      held_y      = '0;
      expected_positions.delete();
    end else begin
      // Track register writes; unknown indexes change nothing
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_X_MIN:    lo_q[AX_X] = cfg_data;
          REG_X_CENTER: mid_q[AX_X] = cfg_data;
          REG_X_MAX:    hi_q[AX_X] = cfg_data;
          REG_Y_MIN:    lo_q[AX_Y] = cfg_data;
          REG_Y_CENTER: mid_q[AX_Y] = cfg_data;
          REG_Y_MAX:    hi_q[AX_Y] = cfg_data;
          REG_DEAD:     dead_q = cfg_data[DB_W-1:0];
          REG_INVERT:   flip_q = cfg_data[INV_W-1:0];
          default: ;
        endcase
      end

      // Compare each result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d, moved %0b) with nothing outstanding",
                                    pos_x, pos_y, moved));
        end else begin
          want = expected_positions.pop_front();
          results_checked++;
          if (pos_x !== want.x)
            report_mismatch($sformatf("pos_x got %0d, want %0d", pos_x, want.x));
          if (pos_y !== want.y)
            report_mismatch($sformatf("pos_y got %0d, want %0d", pos_y, want.y));
          if (moved !== want.moved)
            report_mismatch($sformatf("moved got %0b, want %0b", moved, want.moved));
        end
      end

      // Predict the result of each sample transfer
      if (in_valid && !in_stall) begin
        want.x = axis_percent(raw_x, lo_q[AX_X], mid_q[AX_X], hi_q[AX_X], flip_q[0], dead_q);
        want.y = axis_percent(raw_y, lo_q[AX_Y], mid_q[AX_Y], hi_q[AX_Y], flip_q[1], dead_q);
        want.moved = (want.x != held_x) || (want.y != held_y);
        held_x = want.x;
        held_y = want.y;
        expected_positions.push_back(want);
      end
    end
    pending <= expected_positions.size();
  end

endmodule

// ===== tb/joystick_axis_conditioner_test.sv =====
module joystick_axis_conditioner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jac_pkg::*;

  localparam int ITEM_GOAL      = 1600;
  localparam int CALM_ITEMS     = 200;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int TAIL_CYCLES    = 30;
  localparam int ADC_TOP        = (1 << ADC_BITS) - 1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ADC_BITS-1:0]     raw_x = '0;
  logic [ADC_BITS-1:0]     raw_y = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    moved;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [DATA_W-1:0]       cfg_data = '0;

  int pending;
  int results_checked;
  int errors;
  int quiet_cycles = 0;
  int items_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;
  bit squeeze_req = 1'b0;

  // Stimulus copy of the calibration, used to aim samples at the live range
  int cal_lo [2];
  int cal_mid [2];
  int cal_hi [2];
  logic [ADC_BITS-1:0] prev_pair_x = '0;
  logic [ADC_BITS-1:0] prev_pair_y = '0;

  always #1 clk = ~clk;

  joystick_axis_conditioner u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .moved     (moved),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  joystick_axis_conditioner_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_x           (raw_x),
    .raw_y           (raw_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .moved           (moved),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .results_checked (results_checked),
    .errors          (errors)
  );

  // Give up when no transfer happens on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("** joystick_axis_conditioner: FAILED **");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off, none when calm
  initial begin : receiver
    int  stall_left;
    int  hold_left;
    bit  squeezed;
    stall_left = 0;
    hold_left  = 0;
    squeezed   = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hold valid until the write transfer completes
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input int xl, input int xm, input int xh,
                               input int yl, input int ym, input int yh,
                               input logic [DATA_W-1:0] dead,
                               input logic [DATA_W-1:0] flip);
    write_reg(REG_X_MIN, DATA_W'(xl));
    write_reg(REG_X_CENTER, DATA_W'(xm));
    write_reg(REG_X_MAX, DATA_W'(xh));
    write_reg(REG_Y_MIN, DATA_W'(yl));
    write_reg(REG_Y_CENTER, DATA_W'(ym));
    write_reg(REG_Y_MAX, DATA_W'(yh));
    write_reg(REG_DEAD, dead);
    write_reg(REG_INVERT, flip);
    cfg_valid <= 1'b0;
    cal_lo[0]  = xl;
    cal_mid[0] = xm;
    cal_hi[0]  = xh;
    cal_lo[1]  = yl;
    cal_mid[1] = ym;
    cal_hi[1]  = yh;
    settings_used++;
  endtask

  // Offer one sample pair, sometimes after an idle burst
  task automatic send_pair(input int x, input int y);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_x    <= ADC_BITS'(x);
    raw_y    <= ADC_BITS'(y);
    do @(posedge clk); while (in_stall);
    prev_pair_x = ADC_BITS'(x);
    prev_pair_y = ADC_BITS'(y);
    items_sent++;
  endtask

  // Stop offering and wait until every prediction has been matched
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Aim mostly inside the calibrated range, with edges and noise
  function automatic logic [ADC_BITS-1:0] pick_sample(input int ax);
    int a;
    int m;
    int b;
    int lo_v;
    int hi_v;
    int v;
    a = cal_lo[ax];
    m = cal_mid[ax];
    b = cal_hi[ax];
    lo_v = (a < m) ? a : m;
    lo_v = (b < lo_v) ? b : lo_v;
    hi_v = (a > m) ? a : m;
    hi_v = (b > hi_v) ? b : hi_v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(lo_v, hi_v);
      6: v = m + $urandom_range(0, 16) - 8;
      7: begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = ADC_TOP;
          2: v = a;
          3: v = m;
          4: v = b;
          default: v = m - 1;
        endcase
      end
      default: v = $urandom_range(0, ADC_TOP);
    endcase
    if (v < 0) v = 0;
    if (v > ADC_TOP) v = ADC_TOP;
    return ADC_BITS'(v);
  endfunction

  // New calibration per phase: mostly ordered spans, some degenerate or reversed
  task automatic random_settings();
    int lo_v [2];
    int mid_v [2];
    int hi_v [2];
    logic [DATA_W-1:0] dead;
    logic [DATA_W-1:0] flip;
    for (int ax = 0; ax < 2; ax++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          lo_v[ax]  = $urandom_range(0, 1300);
          mid_v[ax] = lo_v[ax] + $urandom_range(1, 1400);
          hi_v[ax]  = mid_v[ax] + $urandom_range(1, 1390);
        end
        7: begin
          mid_v[ax] = $urandom_range(0, ADC_TOP);
          lo_v[ax]  = $urandom_range(0, 1) ? mid_v[ax] : $urandom_range(0, mid_v[ax]);
          hi_v[ax]  = (lo_v[ax] != mid_v[ax]) ? mid_v[ax] : $urandom_range(mid_v[ax], ADC_TOP);
        end
        8: begin
          lo_v[ax]  = $urandom_range(0, ADC_TOP);
          mid_v[ax] = $urandom_range(0, ADC_TOP);
          hi_v[ax]  = $urandom_range(0, ADC_TOP);
        end
        default: begin
          lo_v[ax]  = 0;
          hi_v[ax]  = ADC_TOP;
          mid_v[ax] = $urandom_range(0, 1) ? 1 : ADC_TOP - 1;
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: dead = DATA_W'($urandom_range(0, 20));
      6, 7: dead = DATA_W'($urandom_range(0, 100));
      8: dead = '0;
      default: dead = DATA_W'($urandom);
    endcase
    flip = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0)
      write_reg(IDX_W'(REG_INVERT) + IDX_W'($urandom_range(1, 8)), DATA_W'($urandom));
    load_settings(lo_v[0], mid_v[0], hi_v[0], lo_v[1], mid_v[1], hi_v[1], dead, flip);
  endtask

  initial begin : stimulus
    int phase_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: full deflections, center, repeats and bit patterns
    send_pair(0, ADC_TOP);
    send_pair(ADC_TOP, 0);
    send_pair(2048, 2048);
    send_pair(2048, 2048);
    send_pair(100, 4000);
    send_pair(2047, 2049);
    send_pair('h555, 'hAAA);
    send_pair('hAAA, 'h555);
    send_pair(1000, 3000);
    send_pair(2100, 2000);
    drain();

    // Unknown register index, widest X span, Y with an empty lower half
    write_reg(IDX_W'(REG_INVERT) + IDX_W'($urandom_range(1, 8)), DATA_W'($urandom));
    load_settings(0, 2048, ADC_TOP, 0, 0, ADC_TOP, 12'h000, 12'h000);
    send_pair(0, 0);
    send_pair(ADC_TOP, ADC_TOP);
    send_pair(2048, 1);
    drain();

    // Both half-spans empty on both axes
    load_settings(2048, 2048, 2048, ADC_TOP, ADC_TOP, ADC_TOP, 12'h000, 12'h001);
    send_pair(0, ADC_TOP);
    send_pair(ADC_TOP, 0);
    send_pair(2048, 4094);
    drain();

    // Reversed calibration order: the clamp bounds the quotient
    load_settings(3000, 1000, 500, ADC_TOP, 2048, 0, 12'h000, 12'h002);
    send_pair(0, ADC_TOP);
    send_pair(2000, 1000);
    send_pair(700, 3000);
    drain();

    // Dead band above full scale zeroes everything
    load_settings(0, 2048, ADC_TOP, 0, 2048, ADC_TOP, 12'hFFF, 12'h003);
    send_pair(0, ADC_TOP);
    send_pair(ADC_TOP, 0);
    send_pair(1, 2);
    drain();

    // Stray high data bits: dead band of exactly full scale, invert Y only
    load_settings(100, 2048, 4000, 100, 2048, 4000, 12'hF64, 12'hFFE);
    send_pair(0, ADC_TOP);
    send_pair(ADC_TOP, 0);
    send_pair(2500, 1500);
    drain();

    // Random phases, each under fresh calibration; idling stops near the end
    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= ITEM_GOAL - CALM_ITEMS) calm = 1'b1;
      random_settings();
      phase_items = $urandom_range(100, 180);
      repeat (phase_items) begin
        if (!squeeze_req && items_sent > 60) squeeze_req = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          send_pair(int'(prev_pair_x), int'(prev_pair_y));
        end else begin
          send_pair(int'(pick_sample(0)), int'(pick_sample(1)));
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d conditioned results from %0d sample pairs", results_checked,
             items_sent);
    $display("under %0d calibration loads, incl. empty and reversed spans", settings_used);
    if (errors == 0) begin
      $display("** joystick_axis_conditioner: PASSED **");
    end else begin
      $display("** joystick_axis_conditioner: FAILED **");
    end
    $finish;
  end

endmodule
